// ===== hw/rtl/lesq_pkg.sv =====
package lesq_pkg;

    localparam int CHAR_W  = 8;
    localparam int SIDE_W  = 11;
    localparam int COORD_W = 10;
    localparam int CFG_W   = 11;

    localparam int DEF_MAX_COLS = 1024;
    localparam int DEF_MAX_ROWS = 1024;

    localparam logic [CFG_W-1:0]  MAP_COLS_RESET = CFG_W'(1);
    localparam logic [CHAR_W-1:0] OBSTACLE_RESET = CHAR_W'(111);

    typedef enum logic [0:0] {
        CFG_MAP_COLS = 1'b0,
        CFG_OBSTACLE = 1'b1
    } cfg_index_t;

endpackage

// ===== hw/rtl/lesq_ram.sv =====
module lesq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/largest_empty_square_scan.sv =====
// Throughput: one cell beat per cycle, also across row ends and map ends, except
// that a map's last cell waits in s1 while s2 and the result register are full.
// Each cell does one read and one write of the previous-row line store,
// which allows that pace; a same-column access is forwarded.
// Reset clears control state and restores the register defaults; the line
// store is not cleared, since every entry is written before it is read.
module largest_empty_square_scan #(
    parameter int MAX_COLS = lesq_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = lesq_pkg::DEF_MAX_ROWS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  lesq_pkg::cfg_index_t          cfg_index,
    input  logic [lesq_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          cell_valid,
    output logic                          cell_ready,
    input  logic [lesq_pkg::CHAR_W-1:0]   cell_req,
    input  logic                          last_cell,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [lesq_pkg::SIDE_W-1:0]   square_size,
    output logic [lesq_pkg::COORD_W-1:0]  end_row,
    output logic [lesq_pkg::COORD_W-1:0]  end_col,
    output logic [lesq_pkg::COORD_W-1:0]  top_row,
    output logic [lesq_pkg::COORD_W-1:0]  left_col
);

    import lesq_pkg::*;

    localparam int CW   = $clog2(MAX_COLS);
    localparam int RW   = $clog2(MAX_ROWS);
    localparam int CMPW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam int DW0  = (RW > CW) ? RW : CW;
    localparam int DW   = ((DW0 > SIDE_W) ? DW0 : SIDE_W) + 1;

    logic [CFG_W-1:0]  map_cols_reg;
    logic [CHAR_W-1:0] obstacle_reg;

    logic [CW-1:0]     col_reg, col_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [CMPW-1:0]   cols_eff;
    logic              row_end;
    logic              accept;

    logic              s1_valid_reg, s1_valid_next;
    logic              s1_last_reg;
    logic              s1_blocked_reg;
    logic              s1_row_end_reg;
    logic              s1_first_reg;
    logic              s1_row0_reg;
    logic [CW-1:0]     s1_col_reg;
    logic [RW-1:0]     s1_row_reg;
    logic              fwd_hit_reg;
    logic [SIDE_W-1:0] fwd_side_reg;
    logic              s1_adv;
    logic              s1_go;

    logic [SIDE_W-1:0] ram_rdata;
    logic [SIDE_W-1:0] up;
    logic [SIDE_W-1:0] min_side;
    logic [SIDE_W-1:0] side;
    logic              better;

    logic [SIDE_W-1:0] left_reg, left_next;
    logic [SIDE_W-1:0] diag_reg, diag_next;
    logic [SIDE_W-1:0] best_side_reg, best_side_next;
    logic [RW-1:0]     best_row_reg, best_row_next;
    logic [CW-1:0]     best_col_reg, best_col_next;
    logic [SIDE_W-1:0] cand_side;
    logic [RW-1:0]     cand_row;
    logic [CW-1:0]     cand_col;

    logic              s2_valid_reg, s2_valid_next;
    logic [SIDE_W-1:0] s2_side_reg;
    logic [RW-1:0]     s2_row_reg;
    logic [CW-1:0]     s2_col_reg;
    logic              s2_free;
    logic              out_load;

    logic [DW-1:0]     span;
    logic [DW-1:0]     top_full;
    logic [DW-1:0]     left_full;

    logic              result_valid_reg, result_valid_next;
    logic [SIDE_W-1:0] square_size_reg;
    logic [COORD_W-1:0] end_row_reg;
    logic [COORD_W-1:0] end_col_reg;
    logic [COORD_W-1:0] top_row_reg;
    logic [COORD_W-1:0] left_col_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_cols_reg <= MAP_COLS_RESET;
            obstacle_reg <= OBSTACLE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAP_COLS: map_cols_reg <= cfg_data;
                CFG_OBSTACLE: obstacle_reg <= cfg_data[CHAR_W-1:0];
                default:      map_cols_reg <= map_cols_reg;
            endcase
        end
    end

    always_comb
    begin
        if (map_cols_reg == '0)
        begin
            cols_eff = CMPW'(1);
        end
        else if (CMPW'(map_cols_reg) > CMPW'(MAX_COLS))
        begin
            cols_eff = CMPW'(MAX_COLS);
        end
        else
        begin
            cols_eff = CMPW'(map_cols_reg);
        end
    end

    assign row_end = (CMPW'(col_reg) + CMPW'(1)) >= cols_eff;

    // Handshake and pipeline advance.
    assign s1_adv     = !s1_last_reg || s2_free;
    assign s1_go      = s1_valid_reg && s1_adv;
    assign cell_ready = !s1_valid_reg || s1_adv;
    assign accept     = cell_valid && cell_ready;
    assign out_load   = s2_valid_reg && (!result_valid_reg || result_ready);
    assign s2_free    = !s2_valid_reg || out_load;

    // Raster position of the next cell.
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (last_cell)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (row_end)
            begin
                col_next = '0;
                if (row_reg != RW'(MAX_ROWS - 1))
                begin
                    row_next = row_reg + RW'(1);
                end
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_last_reg    <= last_cell;
            s1_blocked_reg <= (cell_req == obstacle_reg);
            s1_row_end_reg <= row_end;
            s1_first_reg   <= (row_reg == '0) || (col_reg == '0);
            s1_row0_reg    <= (row_reg == '0);
            s1_col_reg     <= col_reg;
            s1_row_reg     <= row_reg;
            // The cell ahead writes its side in this very cycle.
            fwd_hit_reg    <= s1_go && (s1_col_reg == col_reg);
            fwd_side_reg   <= side;
        end
    end

    lesq_ram #(
        .WIDTH(SIDE_W),
        .DEPTH(MAX_COLS)
    ) u_line (
        .clk  (clk),
        .we   (s1_go),
        .waddr(s1_col_reg),
        .wdata(side),
        .re   (accept),
        .raddr(col_reg),
        .rdata(ram_rdata)
    );

    // Side of the current cell.
    always_comb
    begin
        if (s1_row0_reg)
        begin
            up = '0;
        end
        else if (fwd_hit_reg)
        begin
            up = fwd_side_reg;
        end
        else
        begin
            up = ram_rdata;
        end

        min_side = up;
        if (left_reg < min_side)
        begin
            min_side = left_reg;
        end
        if (diag_reg < min_side)
        begin
            min_side = diag_reg;
        end

        priority if (s1_blocked_reg)
        begin
            side = '0;
        end
        else if (s1_first_reg)
        begin
            side = SIDE_W'(1);
        end
        else
        begin
            side = min_side + SIDE_W'(1);
        end
    end

    assign better = side > best_side_reg;

    always_comb
    begin
        cand_side = better ? side : best_side_reg;
        cand_row  = better ? s1_row_reg : best_row_reg;
        cand_col  = better ? s1_col_reg : best_col_reg;

        left_next      = left_reg;
        diag_next      = diag_reg;
        best_side_next = best_side_reg;
        best_row_next  = best_row_reg;
        best_col_next  = best_col_reg;
        s2_valid_next  = s2_valid_reg;

        if (out_load)
        begin
            s2_valid_next = 1'b0;
        end

        if (s1_go)
        begin
            if (s1_row_end_reg || s1_last_reg)
            begin
                left_next = '0;
                diag_next = '0;
            end
            else
            begin
                left_next = side;
                diag_next = up;
            end

            if (s1_last_reg)
            begin
                best_side_next = '0;
                best_row_next  = '0;
                best_col_next  = '0;
                s2_valid_next  = 1'b1;
            end
            else
            begin
                best_side_next = cand_side;
                best_row_next  = cand_row;
                best_col_next  = cand_col;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            diag_reg      <= '0;
            best_side_reg <= '0;
            best_row_reg  <= '0;
            best_col_reg  <= '0;
            s2_valid_reg  <= 1'b0;
        end
        else
        begin
            left_reg      <= left_next;
            diag_reg      <= diag_next;
            best_side_reg <= best_side_next;
            best_row_reg  <= best_row_next;
            best_col_reg  <= best_col_next;
            s2_valid_reg  <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_last_reg)
        begin
            s2_side_reg <= cand_side;
            s2_row_reg  <= cand_row;
            s2_col_reg  <= cand_col;
        end
    end

    // Top-left corner, clamped at the map edge.
    always_comb
    begin
        span = DW'(s2_side_reg) - DW'(1);
        if (span > DW'(s2_row_reg))
        begin
            top_full = '0;
        end
        else
        begin
            top_full = DW'(s2_row_reg) - span;
        end
        if (span > DW'(s2_col_reg))
        begin
            left_full = '0;
        end
        else
        begin
            left_full = DW'(s2_col_reg) - span;
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (out_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            square_size_reg <= s2_side_reg;
            if (s2_side_reg == '0)
            begin
                end_row_reg  <= '0;
                end_col_reg  <= '0;
                top_row_reg  <= '0;
                left_col_reg <= '0;
            end
            else
            begin
                end_row_reg  <= COORD_W'(s2_row_reg);
                end_col_reg  <= COORD_W'(s2_col_reg);
                top_row_reg  <= COORD_W'(top_full);
                left_col_reg <= COORD_W'(left_full);
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign square_size  = square_size_reg;
    assign end_row      = end_row_reg;
    assign end_col      = end_col_reg;
    assign top_row      = top_row_reg;
    assign left_col     = left_col_reg;

endmodule

// ===== hw/rtl/lesq_checker.sv =====
module lesq_props (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          result_valid,
    input logic                          result_ready,
    input logic [lesq_pkg::SIDE_W-1:0]   square_size,
    input logic [lesq_pkg::COORD_W-1:0]  end_row,
    input logic [lesq_pkg::COORD_W-1:0]  end_col,
    input logic [lesq_pkg::COORD_W-1:0]  top_row,
    input logic [lesq_pkg::COORD_W-1:0]  left_col
);

    import lesq_pkg::*;

    logic [SIDE_W-1:0] row_span;
    logic [SIDE_W-1:0] col_span;
    logic [SIDE_W-1:0] side_span;

    assign row_span  = SIDE_W'(end_row) - SIDE_W'(top_row);
    assign col_span  = SIDE_W'(end_col) - SIDE_W'(left_col);
    assign side_span = square_size - SIDE_W'(1);

    // A result beat that is not taken stays offered.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result beat dropped before it was taken");

    // A map without an empty cell reports all zeros.
    a_empty_map: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && square_size == '0 |->
            end_row == '0 && end_col == '0 && top_row == '0 && left_col == '0)
        else $error("empty map result carries a nonzero corner");

    // The top-left corner never lies past the bottom-right corner.
    a_corner_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && square_size != '0 |-> top_row <= end_row && left_col <= end_col)
        else $error("top-left corner lies past bottom-right corner");

    // The corners are one side apart unless clamped at the map edge.
    a_corner_span: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && square_size != '0 |->
            (row_span == side_span || top_row == '0) &&
            (col_span == side_span || left_col == '0))
        else $error("square corners do not match the reported side");

endmodule

bind largest_empty_square_scan lesq_props u_lesq_props (.*);
